// ===== sv/pirm_pkg.sv =====
// pirm_pkg: shared types and constants of the pacing interval and rate monitor
`timescale 1ns / 1ps
package pirm_pkg;

   localparam int unsigned RATE_NUMERATOR = 60000;

   // configuration register indexes
   localparam logic [2:0] CSR_LRI  = 3'd0;
   localparam logic [2:0] CSR_HRI  = 3'd1;
   localparam logic [2:0] CSR_VRP  = 3'd2;
   localparam logic [2:0] CSR_TOL  = 3'd3;
   localparam logic [2:0] CSR_URL  = 3'd4;
   localparam logic [2:0] CSR_PCT  = 3'd5;
   localparam logic [2:0] CSR_WIN  = 3'd6;

   // event kinds and modes
   localparam logic [1:0] KIND_SENSE = 2'd0;
   localparam logic [1:0] KIND_PACE  = 2'd1;
   localparam logic       MODE_EVENT = 1'b0;
   localparam logic       MODE_REQ   = 1'b1;

   typedef struct packed {
      logic [11:0] lower_rate_interval;
      logic [11:0] hysteresis_interval;
      logic [9:0]  refractory_interval;
      logic [5:0]  slack_ms;
      logic [7:0]  upper_rate_bpm;
      logic [6:0]  pace_ratio_percent;
      logic [17:0] window_length_ms;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic [1:0]  event_kind;
      logic [15:0] interval_ms;
      logic [31:0] timestamp_ms;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        lower_rate_violation;
      logic        hysteresis_violation;
      logic        refractory_violation;
      logic        deadlock_violation;
      logic        hysteresis_active;
      logic        window_has_events;
      logic [7:0]  pace_count;
      logic [7:0]  sense_count;
      logic [15:0] average_bpm;
      logic        pacing_alarm;
      logic        rate_alarm;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic start_event;  // check event and store it in the ring
      logic start_walk;   // begin window walk
      logic read_entry;   // issue memory read at walk pointer
      logic take_entry;   // fold read entry, may start divide
      logic div_step;     // one restoring divide step
      logic add_quot;     // accumulate quotient
      logic start_avg;    // begin final average division
      logic finish;       // form result
   } cmd_type;

   typedef struct packed {
      logic walk_done;    // no entries left
      logic need_div;     // taken entry has nonzero gap
      logic div_done;     // divider finished
   } sts_type;

endpackage

// ===== sv/pirm_if.sv =====
// pirm_stream_if: valid/ready channel carrying a payload
`timescale 1ns / 1ps
interface pirm_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pirm_csr_if.sv =====
// pirm_csr_if: configuration write channel
`timescale 1ns / 1ps
interface pirm_csr_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/pacing_interval_and_rate_monitor.sv =====
// pacing_interval_and_rate_monitor: top level of the pacing monitor
`timescale 1ns / 1ps
// An event transfer is checked and stored in the cycle it is taken, its result offered on the
// next. An analysis request walks every stored entry through the single ring
// read port (states READ, WAIT, TAKE and AVG for each) and runs one restoring divider,
// one bit a cycle over 32 bits, for every nonzero in-window gap and once for the mean.
// One item is in flight at a time; the next is taken once the result is gone.
module pacing_interval_and_rate_monitor #(
   parameter int unsigned EVENT_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   pirm_stream_if.sink   req,
   pirm_stream_if.source rsp,
   pirm_csr_if.sink      csr
);
   import pirm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;
   req_type req_ff;

   assign csr.ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_LRI: cfg_in.lower_rate_interval = csr.wdata[11:0];
            CSR_HRI: cfg_in.hysteresis_interval = csr.wdata[11:0];
            CSR_VRP: cfg_in.refractory_interval = csr.wdata[9:0];
            CSR_TOL: cfg_in.slack_ms            = csr.wdata[5:0];
            CSR_URL: cfg_in.upper_rate_bpm      = csr.wdata[7:0];
            CSR_PCT: cfg_in.pace_ratio_percent  = csr.wdata[6:0];
            CSR_WIN: cfg_in.window_length_ms    = csr.wdata[17:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{12'd1500, 12'd1600, 10'd150, 6'd8, 8'd180, 7'd60, 18'd20000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request capture for the walk
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) req_ff <= req.data;
   end

   req_type req_cur;
   assign req_cur = (req.valid && req.ready) ? req.data : req_ff;

   pirm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.data.mode),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pirm_datapath #(.EVENT_DEPTH(EVENT_DEPTH)) u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_cur),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp.data)
   );
endmodule

// ===== sv/pirm_datapath.sv =====
// pirm_datapath: event ring, interval checks, window walk and serial divider
`timescale 1ns / 1ps
module pirm_datapath #(
   parameter int unsigned EVENT_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  pirm_pkg::cfg_type cfg,
   input  pirm_pkg::req_type req,
   input  pirm_pkg::cmd_type cmd,
   output pirm_pkg::sts_type sts,
   output pirm_pkg::rsp_type rsp
);
   import pirm_pkg::*;

   localparam int unsigned AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int unsigned CW = $clog2(EVENT_DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(EVENT_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(EVENT_DEPTH);
   // sum of up to EVENT_DEPTH rates, each at most 60000
   localparam int unsigned SW = $clog2(EVENT_DEPTH * RATE_NUMERATOR + 1);
   localparam int unsigned DW = (SW > 32) ? SW : 32;

   // event ring
   logic [33:0] mem [EVENT_DEPTH];
   logic [33:0] rd_ff;

   logic [AW-1:0] wpos_ff, wpos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          hyst_ff, hyst_in;

   // walk state
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] paces_ff, paces_in, senses_ff, senses_in, beats_ff, beats_in;
   logic [SW-1:0] total_ff, total_in;
   logic [31:0]   last_ff, last_in;
   logic          entered_ff, entered_in, need_ff, need_in;

   // serial divider
   logic [DW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [$clog2(DW+1)-1:0] step_ff, step_in;

   rsp_type rsp_ff, rsp_in;

   logic [31:0] ts;
   logic [1:0]  kd;
   logic        inwin;
   logic [31:0] gap;
   logic [DW:0] trial;
   logic [18:0] tv, lri_lim, hri_lim;
   logic [10:0] vrp;
   logic [CW:0] tot_ps;
   logic [CW+7:0] lhs, rhs;
   logic [15:0] avg;

   always_comb begin
      ts    = rd_ff[31:0];
      kd    = rd_ff[33:32];
      inwin = (req.timestamp_ms - ts) <= {14'd0, cfg.window_length_ms};
      gap   = ts - last_ff;
      trial = {rem_ff, num_ff[DW-1]} - {{(DW-31){1'b0}}, den_ff};
      tv      = {3'd0, req.interval_ms};
      lri_lim = {7'd0, cfg.lower_rate_interval} + {13'd0, cfg.slack_ms};
      hri_lim = {7'd0, cfg.hysteresis_interval} + {13'd0, cfg.slack_ms};
      vrp     = {1'b0, cfg.refractory_interval} - {5'd0, cfg.slack_ms};
      tot_ps  = {1'b0, paces_ff} + {1'b0, senses_ff};
      lhs     = (CW+8)'(paces_ff) * (CW+8)'(100);
      rhs     = (CW+8)'(tot_ps) * (CW+8)'(cfg.pace_ratio_percent);
      avg     = (beats_ff != '0) ? num_ff[15:0] : 16'd0;
   end

   // next state
   always_comb begin
      wpos_in = wpos_ff; cnt_in = cnt_ff; hyst_in = hyst_ff;
      pos_in = pos_ff; left_in = left_ff; paces_in = paces_ff; senses_in = senses_ff;
      beats_in = beats_ff; total_in = total_ff; last_in = last_ff;
      entered_in = entered_ff; need_in = need_ff;
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; step_in = step_ff;
      rsp_in = rsp_ff;
      if (cmd.start_event) begin
         rsp_in = '0;
         rsp_in.lower_rate_violation = !hyst_ff && (tv > lri_lim);
         rsp_in.hysteresis_violation = hyst_ff && (tv > hri_lim);
         rsp_in.refractory_violation = !vrp[10] && ({3'd0, req.interval_ms} <= {8'd0, vrp});
         rsp_in.deadlock_violation   = tv > hri_lim;
         if (req.event_kind == KIND_SENSE) hyst_in = 1'b1;
         else if (req.event_kind == KIND_PACE) hyst_in = 1'b0;
         rsp_in.hysteresis_active = (req.event_kind == KIND_SENSE) ? 1'b1 :
                                    (req.event_kind == KIND_PACE) ? 1'b0 : hyst_ff;
         wpos_in = (wpos_ff == LAST_POS) ? '0 : wpos_ff + 1'b1;
         if (cnt_ff != FULL_CNT) cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.start_walk) begin
         pos_in = (wpos_ff >= AW'(cnt_ff)) && (cnt_ff != FULL_CNT) ?
                  wpos_ff - AW'(cnt_ff) : AW'({1'b0, wpos_ff} + CW'(EVENT_DEPTH) - cnt_ff);
         left_in = cnt_ff;
         paces_in = '0; senses_in = '0; beats_in = '0; total_in = '0;
         entered_in = 1'b0; need_in = 1'b0;
      end
      if (cmd.read_entry) begin
         pos_in  = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
         left_in = left_ff - 1'b1;
      end
      if (cmd.take_entry) begin
         need_in = 1'b0;
         if (inwin) begin
            if (kd == KIND_SENSE) senses_in = senses_ff + 1'b1;
            if (kd == KIND_PACE)  paces_in  = paces_ff + 1'b1;
            if (entered_ff && gap != '0) begin
               need_in = 1'b1;
               num_in  = DW'(RATE_NUMERATOR);
               rem_in  = '0;
               den_in  = gap;
               step_in = '0;
               beats_in = beats_ff + 1'b1;
            end
            entered_in = 1'b1;
            last_in = ts;
         end
      end
      if (cmd.start_avg) begin
         num_in  = DW'(total_ff);
         rem_in  = '0;
         den_in  = 32'(beats_ff);
         step_in = '0;
      end
      if (cmd.div_step) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            num_in = {num_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-2:0], num_ff[DW-1]};
            num_in = {num_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
      end
      if (cmd.add_quot) total_in = total_ff + SW'(num_ff);
      if (cmd.finish) begin
         rsp_in = '0;
         rsp_in.result_kind = MODE_REQ;
         rsp_in.hysteresis_active = hyst_ff;
         if (entered_ff) begin
            rsp_in.window_has_events = 1'b1;
            rsp_in.pace_count  = (paces_ff > CW'(255)) ? 8'd255 : 8'(paces_ff);
            rsp_in.sense_count = (senses_ff > CW'(255)) ? 8'd255 : 8'(senses_ff);
            rsp_in.average_bpm = avg;
            rsp_in.rate_alarm  = (beats_ff != '0) && (avg > {8'd0, cfg.upper_rate_bpm});
            rsp_in.pacing_alarm = lhs > rhs;
         end
      end
   end

   // ring write and registered read, held until the entry is taken
   always_ff @(posedge clock) begin
      if (cmd.start_event) mem[wpos_ff] <= {req.event_kind, req.timestamp_ms};
      if (cmd.read_entry) rd_ff <= mem[pos_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0; cnt_ff <= '0; hyst_ff <= 1'b0;
      end else begin
         wpos_ff <= wpos_in; cnt_ff <= cnt_in; hyst_ff <= hyst_in;
      end
   end

   // walk and divider registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in; left_ff <= left_in; paces_ff <= paces_in; senses_ff <= senses_in;
      beats_ff <= beats_in; total_ff <= total_in; last_ff <= last_in;
      entered_ff <= entered_in; need_ff <= need_in;
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

   assign sts.walk_done = (left_ff == '0);
   assign sts.need_div  = need_ff;
   assign sts.div_done  = (step_ff == ($clog2(DW+1))'(DW));
   assign rsp = rsp_ff;

   // a pace never leaves hysteresis set
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_event && req.event_kind == KIND_PACE |=> !hyst_ff)
      else $error("hysteresis flag kept after pace");
   // stored count never exceeds ring depth
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= FULL_CNT)
      else $error("stored count beyond depth");
   // divider stops at its width
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> step_ff < ($clog2(DW+1))'(DW))
      else $error("divider stepped past end");
endmodule

// ===== sv/pirm_control.sv =====
// pirm_control: sequencer for event checks and window analysis
`timescale 1ns / 1ps
module pirm_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pirm_pkg::sts_type sts,
   output pirm_pkg::cmd_type cmd
);
   import pirm_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_EVENT = 10'b0000000010,
      ST_READ  = 10'b0000000100,
      ST_WAIT  = 10'b0000001000,
      ST_TAKE  = 10'b0000010000,
      ST_DIV   = 10'b0000100000,
      ST_ADD   = 10'b0001000000,
      ST_AVG   = 10'b0010000000,
      ST_FIN   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      avg_ff, avg_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      avg_in   = avg_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_EVENT) begin
                  cmd.start_event = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  cmd.start_walk = 1'b1;
                  avg_in   = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_EVENT: state_in = ST_OUT;
         ST_READ: begin
            if (sts.walk_done) begin
               cmd.start_avg = 1'b1;
               avg_in   = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.read_entry = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_TAKE;
         ST_TAKE: begin
            cmd.take_entry = 1'b1;
            state_in = ST_AVG;
         end
         ST_AVG: state_in = sts.need_div ? ST_DIV : ST_READ;
         ST_DIV: begin
            if (sts.div_done) state_in = avg_ff ? ST_FIN : ST_ADD;
            else cmd.div_step = 1'b1;
         end
         ST_ADD: begin
            cmd.add_quot = 1'b1;
            state_in = ST_READ;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         avg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         avg_ff   <= avg_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("accepting while result pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
endmodule

// ===== bench/tb_pacing_interval_and_rate_monitor.sv =====
// tb_pacing_interval_and_rate_monitor: self-checking bench for the pacing interval and rate monitor
`timescale 1ns / 1ps
module tb_pacing_interval_and_rate_monitor;
   import pirm_pkg::*;

   localparam int unsigned RING_DEPTH  = 128;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int unsigned STALL_LONG  = 400;
   localparam logic [1:0]  KIND_OTHER  = 2'd2;
   localparam logic [1:0]  KIND_SPARE  = 2'd3;

   logic clock;
   logic reset;

   pirm_stream_if #(.payload_type(req_type)) req (.clock(clock));
   pirm_stream_if #(.payload_type(rsp_type)) rsp (.clock(clock));
   pirm_csr_if csr (.clock(clock));

   pacing_interval_and_rate_monitor #(.EVENT_DEPTH(RING_DEPTH)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // predictor state
   cfg_type     cur_cfg;
   logic        flag_hyst;
   logic [31:0] ring_time [RING_DEPTH];
   logic [1:0]  ring_kind [RING_DEPTH];
   int unsigned wr_pos;
   int unsigned fill_count;

   rsp_type     pending_rsp[$];
   int unsigned errors;
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned n_events;
   int unsigned n_requests;
   int unsigned n_checked;
   bit          no_idle;
   bit          pressure_armed;
   bit          pressure_done;
   int unsigned rsp_stall_left;
   logic [31:0] now_ms;

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("pacing_interval_and_rate_monitor verification failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned reg_width(logic [2:0] idx);
      case (idx)
         CSR_LRI, CSR_HRI: return 12;
         CSR_VRP:          return 10;
         CSR_TOL:          return 6;
         CSR_URL:          return 8;
         CSR_PCT:          return 7;
         default:          return 18;
      endcase
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         CSR_LRI: cur_cfg.lower_rate_interval = val[11:0];
         CSR_HRI: cur_cfg.hysteresis_interval = val[11:0];
         CSR_VRP: cur_cfg.refractory_interval = val[9:0];
         CSR_TOL: cur_cfg.slack_ms            = val[5:0];
         CSR_URL: cur_cfg.upper_rate_bpm      = val[7:0];
         CSR_PCT: cur_cfg.pace_ratio_percent  = val[6:0];
         CSR_WIN: cur_cfg.window_length_ms    = val[17:0];
         default: ;
      endcase
   endfunction

   // expected result of one item; updates the predictor state
   function automatic rsp_type monitor_predict(req_type it);
      rsp_type     r;
      int          tv, tol, hri_lim;
      int unsigned cnt, pos, paces, senses, beats, total, avg;
      logic [31:0] last, gap, t;
      bit          entered;
      r = '0;
      if (it.mode == MODE_EVENT) begin
         tv      = int'(it.interval_ms);
         tol     = int'(cur_cfg.slack_ms);
         hri_lim = int'(cur_cfg.hysteresis_interval) + tol;
         r.lower_rate_violation = !flag_hyst && tv > int'(cur_cfg.lower_rate_interval) + tol;
         r.hysteresis_violation = flag_hyst && tv > hri_lim;
         r.refractory_violation = tv <= int'(cur_cfg.refractory_interval) - tol;
         r.deadlock_violation   = tv > hri_lim;
         if (it.event_kind == KIND_SENSE) flag_hyst = 1'b1;
         else if (it.event_kind == KIND_PACE) flag_hyst = 1'b0;
         r.hysteresis_active = flag_hyst;
         ring_time[wr_pos] = it.timestamp_ms;
         ring_kind[wr_pos] = it.event_kind;
         wr_pos = (wr_pos + 1 >= RING_DEPTH) ? 0 : wr_pos + 1;
         if (fill_count < RING_DEPTH) fill_count++;
      end else begin
         paces = 0; senses = 0; beats = 0; total = 0; avg = 0;
         last = '0; entered = 0;
         cnt = fill_count;
         pos = (wr_pos >= cnt) ? wr_pos - cnt : wr_pos + RING_DEPTH - cnt;
         // oldest first over the stored entries
         for (int unsigned i = 0; i < cnt; i++) begin
            t = ring_time[pos];
            if (32'(it.timestamp_ms - t) <= 32'(cur_cfg.window_length_ms)) begin
               if (ring_kind[pos] == KIND_SENSE) senses++;
               if (ring_kind[pos] == KIND_PACE) paces++;
               if (entered) begin
                  gap = t - last;
                  if (gap != 0) begin
                     total += RATE_NUMERATOR / gap;
                     beats++;
                  end
               end
               entered = 1;
               last = t;
            end
            pos = (pos + 1 >= RING_DEPTH) ? 0 : pos + 1;
         end
         r.result_kind = 1'b1;
         r.hysteresis_active = flag_hyst;
         if (entered) begin
            r.window_has_events = 1'b1;
            r.pace_count  = (paces > 255) ? 8'd255 : 8'(paces);
            r.sense_count = (senses > 255) ? 8'd255 : 8'(senses);
            if (beats != 0) begin
               avg = total / beats;
               r.rate_alarm = avg > cur_cfg.upper_rate_bpm;
            end
            r.average_bpm = 16'(avg);
            r.pacing_alarm = longint'(paces) * 100 >
                             longint'(cur_cfg.pace_ratio_percent) * longint'(paces + senses);
         end
      end
      return r;
   endfunction

   // offer one item, wait for its transfer
   task automatic send_item(req_type it, bit fixed, rsp_type fixed_rsp);
      int unsigned gap;
      rsp_type     p;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= it;
      do @(posedge clock); while (!req.ready);
      p = monitor_predict(it);
      pending_rsp.push_back(fixed ? fixed_rsp : p);
      if (it.mode == MODE_EVENT) n_events++;
      else n_requests++;
   endtask

   // drain all results before touching registers
   task automatic settle();
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one register transfer; the caller drops valid after the last one
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      int unsigned w;
      w = reg_width(idx);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.wdata <= ($urandom << w) | (val & ((32'd1 << w) - 1));
      do @(posedge clock); while (!csr.ready);
      apply_reg(idx, val);
   endtask

   task automatic write_cfg(cfg_type c);
      write_reg(CSR_LRI, c.lower_rate_interval);
      write_reg(CSR_HRI, c.hysteresis_interval);
      write_reg(CSR_VRP, c.refractory_interval);
      write_reg(CSR_TOL, c.slack_ms);
      write_reg(CSR_URL, c.upper_rate_bpm);
      write_reg(CSR_PCT, c.pace_ratio_percent);
      write_reg(CSR_WIN, c.window_length_ms);
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.lower_rate_interval = $urandom_range(300, 2000);
      c.hysteresis_interval = $urandom_range(300, 2200);
      c.refractory_interval = $urandom_range(0, 1023);
      c.slack_ms            = $urandom_range(0, 63);
      c.upper_rate_bpm      = $urandom_range(0, 255);
      c.pace_ratio_percent  = $urandom_range(0, 127);
      c.window_length_ms    = $urandom_range(0, 262143);
      return c;
   endfunction

   // random item: mostly a plausible heart rhythm, a little noise
   function automatic req_type random_item(int unsigned req_pct);
      req_type it;
      int unsigned r;
      it.mode = ($urandom_range(0, 99) < req_pct) ? MODE_REQ : MODE_EVENT;
      it.event_kind = $urandom_range(0, 99) < 10 ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      it.interval_ms = (r < 15) ? 16'($urandom) : 16'($urandom_range(100, 2200));
      r = $urandom_range(0, 99);
      if (it.mode == MODE_EVENT) begin
         if (r < 10) now_ms = now_ms;
         else if (r < 95) now_ms = now_ms + $urandom_range(250, 1300);
         else now_ms = now_ms + $urandom;
         it.timestamp_ms = now_ms;
      end else begin
         it.timestamp_ms = (r < 8) ? $urandom : now_ms + $urandom_range(0, 600);
      end
      return it;
   endfunction

   task automatic random_run(int unsigned count, int unsigned req_pct);
      req_type it;
      for (int unsigned i = 0; i < count; i++) begin
         it = random_item(req_pct);
         send_item(it, 1'b0, '0);
      end
   endtask

   // result side: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (pressure_armed && !pressure_done) begin
         pressure_done = 1;
         rsp_stall_left = STALL_LONG;
         rsp.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp.ready <= 1'b0;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_stall_left = g - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("unexpected result %p", rsp.data);
            mismatches++;
         end else begin
            e = pending_rsp.pop_front();
            n_checked++;
            if (rsp.data !== e) begin
               errors++;
               if (mismatches < 10) $display("mismatch\n  exp %p\n  act %p", e, rsp.data);
               mismatches++;
            end
         end
      end
   end

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type result;
   } row_type;

   row_type rows[$];

   function automatic row_type mk_row(logic mode, logic [1:0] kind, logic [15:0] iv,
                                      logic [31:0] ts, bit fixed, rsp_type res);
      row_type row;
      row.item.mode = mode;
      row.item.event_kind = kind;
      row.item.interval_ms = iv;
      row.item.timestamp_ms = ts;
      row.fixed = fixed;
      row.result = res;
      return row;
   endfunction

   initial begin
      rsp_type fx;
      cfg_type c;
      errors = 0; mismatches = 0; cycles = 0; n_checked = 0;
      n_events = 0; n_requests = 0;
      no_idle = 0; pressure_armed = 0; pressure_done = 0;
      reset = 1'b1;
      req.valid <= 1'b0;
      req.data  <= '0;
      csr.valid <= 1'b0;
      csr.index <= CSR_LRI;
      csr.wdata <= '0;
      cur_cfg.lower_rate_interval = 1500;
      cur_cfg.hysteresis_interval = 1600;
      cur_cfg.refractory_interval = 150;
      cur_cfg.slack_ms            = 8;
      cur_cfg.upper_rate_bpm      = 180;
      cur_cfg.pace_ratio_percent  = 60;
      cur_cfg.window_length_ms    = 20000;
      flag_hyst = 0; wr_pos = 0; fill_count = 0;
      now_ms = 32'd5000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings
      fx = '0; fx.result_kind = 1'b1;
      rows.push_back(mk_row(MODE_REQ, KIND_SENSE, 16'd0, 32'd1000, 1, fx));
      fx = '0; fx.lower_rate_violation = 1; fx.deadlock_violation = 1;
      fx.hysteresis_active = 1;
      rows.push_back(mk_row(MODE_EVENT, KIND_SENSE, 16'hFFFF, 32'd1000, 1, fx));
      fx = '0; fx.refractory_violation = 1;
      rows.push_back(mk_row(MODE_EVENT, KIND_PACE, 16'd0, 32'd1800, 1, fx));
      rows.push_back(mk_row(MODE_EVENT, KIND_OTHER, 16'd1508, 32'd2600, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_SPARE, 16'd1509, 32'd2600, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_SENSE, 16'd142, 32'd3400, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_SENSE, 16'd143, 32'd3700, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_SENSE, 16'd1609, 32'd4000, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_PACE, 16'd1608, 32'd4500, 0, '0));
      rows.push_back(mk_row(MODE_REQ, KIND_PACE, 16'hFFFF, 32'd4500, 0, '0));
      rows.push_back(mk_row(MODE_REQ, KIND_SENSE, 16'd0, 32'd100, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_SENSE, 16'd800, 32'hFFFF_FF00, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_PACE, 16'd800, 32'h0000_0080, 0, '0));
      rows.push_back(mk_row(MODE_REQ, KIND_OTHER, 16'd0, 32'h0000_0100, 0, '0));
      rows.push_back(mk_row(MODE_EVENT, KIND_PACE, 16'hFFFF, 32'hFFFF_FFFF, 0, '0));
      rows.push_back(mk_row(MODE_REQ, KIND_SPARE, 16'hAAAA, 32'hFFFF_FFFF, 0, '0));
      foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].result);
      settle();

      // every register at its maximum
      c.lower_rate_interval = 12'hFFF; c.hysteresis_interval = 12'hFFF;
      c.refractory_interval = 10'h3FF; c.slack_ms = 6'h3F;
      c.upper_rate_bpm = 8'hFF; c.pace_ratio_percent = 7'h7F;
      c.window_length_ms = 18'h3FFFF;
      write_cfg(c);
      csr.valid <= 1'b0;
      now_ms = $urandom;
      random_run(10, 30);
      settle();

      // every register at zero, no idling
      write_cfg('0);
      csr.valid <= 1'b0;
      no_idle = 1;
      random_run(8, 30);
      settle();
      no_idle = 0;

      // wide window with a long result hold-off
      write_cfg(random_cfg());
      write_reg(CSR_WIN, 18'h3FFFF);
      csr.valid <= 1'b0;
      for (int unsigned i = 0; i < 60; i++) begin
         if (i == 10) pressure_armed = 1;
         send_item(random_item((i % 20 == 19) ? 100 : 0), 1'b0, '0);
      end
      random_run(4, 100);
      settle();

      // random settings
      for (int p = 0; p < 2; p++) begin
         write_cfg(random_cfg());
         write_reg(CSR_PCT, $urandom_range(0, 100));
         csr.valid <= 1'b0;
         random_run(11, 35);
         settle();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d events and %0d window analyses, %0d results checked",
               n_events, n_requests, n_checked);
      $display("settings: reset, all maxima, all zero, long result stall, random");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("pacing_interval_and_rate_monitor verification clean");
      end else begin
         $display("pacing_interval_and_rate_monitor verification failed");
      end
      $finish;
   end

endmodule

// ===== pacing_interval_and_rate_monitor.f =====
sv/pirm_pkg.sv
sv/pirm_if.sv
sv/pirm_csr_if.sv
sv/pirm_datapath.sv
sv/pirm_control.sv
sv/pacing_interval_and_rate_monitor.sv
bench/tb_pacing_interval_and_rate_monitor.sv
